// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the speed ramp RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk edge outside reset.
`define LSRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clk edge, reset included.
`define LSRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/lsrg_pkg.sv =====
// Package: types and constants of the linear speed ramp generator.
`default_nettype none
package lsrg_pkg;

  localparam int SPEED_W   = 28;  // internal speed, rpm * scale, signed
  localparam int RPM_W     = 16;
  localparam int TGT_W     = 17;
  localparam int DUR_W     = 16;
  localparam int DIV_W     = 26;  // dividend magnitude bits
  localparam int DIVCNT_W  = $clog2(DIV_W + 1);
  localparam int IN_DATA_W = 40;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_FREEZE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_GOAL,
    S_EVAL,
    S_SDIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;     // latch input beat
    logic apply;      // tick / freeze / clear
    logic goal_ld;    // clamp and scale requested rpm
    logic eval;       // commit goal, decide step
    logic div_start;
    logic step_ld;    // step from quotient
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    need_div;
    logic    div_done;
    logic    out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/lsrg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"
module lsrg_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [lsrg_pkg::DIV_W-1:0]  dividend,
  input  wire logic [lsrg_pkg::DUR_W-1:0]  divisor,
  output logic      [lsrg_pkg::DIV_W-1:0]  quotient,
  output logic                             done
);
  import lsrg_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DIVCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DUR_W-1:0]    rem_r, rem_nxt;
  logic [DUR_W-1:0]    divisor_r, divisor_nxt;
  logic [DIV_W-1:0]    q_r, q_nxt;
  logic [DUR_W:0]      shifted;
  logic [DUR_W:0]      diff;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, divisor_r};

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    q_nxt       = q_r;
    if (start) begin
      busy_nxt    = 1'b1;
      divisor_nxt = divisor;
      cnt_nxt     = DIVCNT_W'(DIV_W);
      rem_nxt     = '0;
      q_nxt       = dividend;
    end else if (busy_r) begin
      if (!diff[DUR_W]) begin
        rem_nxt = diff[DUR_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DUR_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIVCNT_W'(1);
      if (cnt_r == DIVCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    q_r       <= q_nxt;
  end

  assign quotient = q_r;
  assign done     = done_r;

  `LSRG_ASSERT(a_rem_below_divisor, busy_r |-> (rem_r < divisor_r), "divider remainder overflow")
  `LSRG_ASSERT(a_done_ends_busy, done_r |-> !busy_r, "divider done while busy")

endmodule
`default_nettype wire

// ===== rtl/core/lsrg_dp.sv =====
// Datapath: ramp state, set evaluation, tick update and output register.
`default_nettype none
`include "assert_macros.svh"
module lsrg_dp #(
  parameter int SPEED_SCALE = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lsrg_pkg::ctrl_cmd_t            cmd,
  output lsrg_pkg::ctrl_sts_t                 sts,
  input  wire logic [lsrg_pkg::RPM_W-1:0]     max_rpm,
  input  wire logic [1:0]                     in_action,
  input  wire logic [lsrg_pkg::TGT_W-1:0]     in_target,
  input  wire logic [lsrg_pkg::DUR_W-1:0]     in_duration,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [lsrg_pkg::RPM_W-1:0]     out_rpm,
  output logic                                out_at_target
);
  import lsrg_pkg::*;

  localparam int ScaleW = $clog2(SPEED_SCALE + 1);
  localparam int ProdW  = RPM_W + ScaleW;

  // speed / SPEED_SCALE as a multiply by a rounded-up reciprocal;
  // exact for every speed below 2**DIV_W
  localparam int CmdShift = DIV_W + $clog2(SPEED_SCALE);
  localparam int CmdProdW = 2 * DIV_W + 1;
  localparam logic [63:0] CmdRecipFull =
      ((64'd1 << CmdShift) + 64'(SPEED_SCALE - 1)) / 64'(SPEED_SCALE);
  localparam logic [DIV_W:0] CmdRecip = CmdRecipFull[DIV_W:0];

  action_t                    act_r;
  logic signed [TGT_W-1:0]    tgt_r;
  logic [DUR_W-1:0]           dur_r;

  logic signed [SPEED_W-1:0]  now_r, now_nxt;
  logic signed [SPEED_W-1:0]  goal_r, goal_nxt;
  logic signed [SPEED_W-1:0]  step_r, step_nxt;
  logic signed [SPEED_W-1:0]  goal_tmp_r, goal_tmp_nxt;
  logic                       neg_r, neg_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [RPM_W-1:0]           out_rpm_r, out_rpm_nxt;
  logic                       out_at_r, out_at_nxt;

  logic [RPM_W-1:0]           rpm_cl;
  logic [ProdW-1:0]           prod;
  logic signed [SPEED_W-1:0]  delta;
  logic [SPEED_W-1:0]         delta_mag;
  logic signed [SPEED_W:0]    next_sum;
  logic signed [SPEED_W:0]    goal_ext;
  logic [DIV_W-1:0]           quot;
  logic [DIV_W-1:0]           q_fix;
  logic                       div_done;
  logic [CmdProdW-1:0]        cmd_prod;
  logic [RPM_W-1:0]           rpm_now;

  // clamp requested rpm to 0..max_rpm, then scale
  always_comb begin
    if (tgt_r[TGT_W-1]) begin
      rpm_cl = '0;
    end else if (tgt_r[RPM_W-1:0] > max_rpm) begin
      rpm_cl = max_rpm;
    end else begin
      rpm_cl = tgt_r[RPM_W-1:0];
    end
  end

  assign prod      = ProdW'(rpm_cl) * ProdW'(SPEED_SCALE);
  assign delta     = goal_tmp_r - now_r;
  assign delta_mag = delta[SPEED_W-1] ? SPEED_W'(-delta) : SPEED_W'(delta);
  assign next_sum  = (SPEED_W+1)'(now_r) + (SPEED_W+1)'(step_r);
  assign goal_ext  = (SPEED_W+1)'(goal_r);
  assign q_fix     = (quot == '0) ? DIV_W'(1) : quot;

  // speed is never negative, so the low DIV_W bits carry it whole
  assign cmd_prod = CmdProdW'(now_r[DIV_W-1:0]) * CmdProdW'(CmdRecip);
  assign rpm_now  = cmd_prod[CmdShift +: RPM_W];

  lsrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (delta_mag[DIV_W-1:0]),
    .divisor  (dur_r),
    .quotient (quot),
    .done     (div_done)
  );

  always_comb begin
    now_nxt      = now_r;
    goal_nxt     = goal_r;
    step_nxt     = step_r;
    goal_tmp_nxt = goal_tmp_r;
    neg_nxt      = neg_r;
    if (cmd.apply) begin
      unique case (act_r)
        ACT_TICK: begin
          if ((step_r != '0) && (now_r != goal_r)) begin
            // clamp at the goal in the step's direction
            if ((!step_r[SPEED_W-1] && (next_sum > goal_ext)) ||
                (step_r[SPEED_W-1] && (next_sum < goal_ext))) begin
              now_nxt = goal_r;
            end else begin
              now_nxt = next_sum[SPEED_W-1:0];
            end
            if (now_nxt == goal_r) begin
              step_nxt = '0;
            end
          end
        end
        ACT_FREEZE: begin
          goal_nxt = now_r;
          step_nxt = '0;
        end
        ACT_CLEAR: begin
          now_nxt  = '0;
          goal_nxt = '0;
          step_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd.goal_ld) begin
      goal_tmp_nxt = $signed(SPEED_W'(prod));
    end
    if (cmd.eval) begin
      goal_nxt = goal_tmp_r;
      neg_nxt  = delta[SPEED_W-1];
      if (!sts.need_div) begin
        step_nxt = delta;  // zero delta, or a jump
      end
    end
    if (cmd.step_ld) begin
      step_nxt = neg_r ? -$signed(SPEED_W'(q_fix)) : $signed(SPEED_W'(q_fix));
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rpm_nxt   = out_rpm_r;
    out_at_nxt    = out_at_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_rpm_nxt   = rpm_now;
      out_at_nxt    = (now_r == goal_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      goal_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      now_r       <= now_nxt;
      goal_r      <= goal_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    goal_tmp_r <= goal_tmp_nxt;
    neg_r      <= neg_nxt;
    out_rpm_r  <= out_rpm_nxt;
    out_at_r   <= out_at_nxt;
    if (cmd.accept) begin
      act_r <= action_t'(in_action);
      tgt_r <= in_target;
      dur_r <= in_duration;
    end
  end

  assign sts.action   = act_r;
  assign sts.need_div = (delta != '0) && (dur_r != '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid    = out_valid_r;
  assign out_rpm       = out_rpm_r;
  assign out_at_target = out_at_r;

  `LSRG_ASSERT(a_speed_nonneg, !now_r[SPEED_W-1], "current speed went negative")
  `LSRG_ASSERT(a_step_zero_at_goal, (now_r == goal_r) |-> (step_r == '0),
               "nonzero step while at goal")

endmodule
`default_nettype wire

// ===== rtl/core/lsrg_ctrl.sv =====
// Controller: sequences one beat through apply, divide and output load.
`default_nettype none
`include "assert_macros.svh"
module lsrg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire lsrg_pkg::ctrl_sts_t  sts,
  output lsrg_pkg::ctrl_cmd_t       cmd
);
  import lsrg_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY:  state_nxt = (sts.action == ACT_SET) ? S_GOAL : S_OUT;
      S_GOAL:   state_nxt = S_EVAL;
      S_EVAL:   state_nxt = sts.need_div ? S_SDIV : S_OUT;
      S_SDIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_APPLY: cmd.apply = 1'b1;
      S_GOAL:  cmd.goal_ld = 1'b1;
      S_EVAL: begin
        cmd.eval      = 1'b1;
        cmd.div_start = sts.need_div;
      end
      S_SDIV:  cmd.step_ld = sts.div_done;
      S_OUT:   cmd.out_load = sts.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LSRG_ASSERT(a_load_when_free, cmd.out_load |-> sts.out_free,
               "output register overwritten")

endmodule
`default_nettype wire

// ===== rtl/core/linear_speed_ramp_generator.sv =====
// Top level of the linear speed ramp generator: config register and wiring.
`default_nettype none
// Each input beat (tick, set, freeze or clear) yields one output beat with the
// rpm command and the at-target flag after the action is applied. One beat is
// handled at a time. Tick, freeze and clear go from accept through the apply
// state to output load. A set goes through apply, goal load and evaluate; one
// that jumps (zero duration) or lands on the current speed then goes straight
// to output load, and any other set runs a restoring divider for the step
// (speed delta over duration, 26 iterations, one quotient bit per cycle)
// before output load. The rpm command comes from a reciprocal multiply in the
// output load cycle. A finished output beat waits in an output register, so
// the next input beat is taken while it is still pending; a beat that finishes
// while the previous one is still held waits until that one leaves. max_rpm
// sits at byte address 0; the user must write it only while the block is idle,
// as the block itself does not enforce this; it affects later set beats only.
module linear_speed_ramp_generator #(
  parameter int SPEED_SCALE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [16:0] target_rpm, [32:17] duration_ticks, [39:33] zero
  input  wire logic [39:0] in_tdata,
  // in_tuser: [1:0] action
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: [15:0] rpm_command
  output logic [15:0]      out_tdata,
  // out_tuser: [0] at_target
  output logic [0:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import lsrg_pkg::*;

  localparam logic [RPM_W-1:0] MaxRpmReset = '1;

  logic [RPM_W-1:0] max_rpm_r, max_rpm_nxt;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;
  logic [RPM_W-1:0] out_rpm;
  logic             out_at;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    max_rpm_nxt = max_rpm_r;
    if (cfg_wr && !cfg_paddr[2]) begin
      max_rpm_nxt = cfg_pwdata[RPM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rpm_r <= MaxRpmReset;
    end else begin
      max_rpm_r <= max_rpm_nxt;
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(max_rpm_r);

  lsrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsrg_dp #(
    .SPEED_SCALE (SPEED_SCALE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .max_rpm       (max_rpm_r),
    .in_action     (in_tuser),
    .in_target     (in_tdata[TGT_W-1:0]),
    .in_duration   (in_tdata[TGT_W+DUR_W-1:TGT_W]),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_rpm       (out_rpm),
    .out_at_target (out_at)
  );

  assign out_tdata = out_rpm;
  assign out_tuser = out_at;

endmodule
`default_nettype wire
